// ===== rtl/square_wave_channel_sweep_unit_defines.svh =====
// assertion macros for the square wave channel sweep unit
`ifndef SQUARE_WAVE_CHANNEL_SWEEP_UNIT_DEFINES_SVH
`define SQUARE_WAVE_CHANNEL_SWEEP_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// property that must hold at every clock edge outside reset
`define SQSW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property that must hold in the cycle after a trigger condition
`define SQSW_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define SQSW_ASSERT(label, clk, rst, prop, msg)
`define SQSW_ASSERT_NEXT(label, clk, rst, cond, prop, msg)
`endif

`endif

// ===== rtl/sqsw_pkg.sv =====
`timescale 1ns / 1ps

package sqsw_pkg;

   // field and state widths
   localparam int FREQ_W      = 11;
   localparam int TIMER_W     = 14;
   localparam int WAVE_W      = 3;
   localparam int DUTY_W      = 2;
   localparam int SWP_PER_W   = 3;
   localparam int SWP_CNT_W   = 4;
   localparam int SHIFT_W     = 3;
   localparam int VOL_W       = 4;
   localparam int BYTE_W      = 8;
   localparam int REG_IDX_W   = 3;

   // sweep countdown reload when the period is zero
   localparam logic [SWP_CNT_W-1:0] SWEEP_IDLE_RELOAD = 4'd8;

   // item operations
   typedef enum logic [1:0] {
      OP_TIMER = 2'd0,
      OP_SWEEP = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // channel register numbers
   localparam logic [REG_IDX_W-1:0] REG_SWEEP    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DUTY     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ENVELOPE = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FREQ_LO  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_FREQ_HI  = 3'd4;

   // read-back filler for unused bits
   localparam logic [BYTE_W-1:0] RD_SWEEP_FILL = 8'h80;
   localparam logic [BYTE_W-1:0] RD_DUTY_FILL  = 8'h3f;
   localparam logic [BYTE_W-1:0] RD_HI_FILL    = 8'hbf;
   localparam logic [BYTE_W-1:0] RD_ALL_ONES   = 8'hff;

   // result of one sweep calculation
   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic              overflow;
   } sweep_result_type;

   // timer reload, (2048 - frequency) * 4
   function automatic logic [TIMER_W-1:0] reload_value(input logic [FREQ_W-1:0] freq);
      logic [FREQ_W:0] diff;
      diff = {1'b1, {FREQ_W{1'b0}}} - {1'b0, freq};
      return {diff, 2'b00};
   endfunction

   // duty waveform, bit p of each pattern is wave position p
   function automatic logic duty_bit(input logic [DUTY_W-1:0] duty,
                                     input logic [WAVE_W-1:0] pos);
      logic [7:0] pattern;
      case (duty)
         2'd0:    pattern = 8'b1000_0000;
         2'd1:    pattern = 8'b1000_0001;
         2'd2:    pattern = 8'b1110_0001;
         default: pattern = 8'b0111_1110;
      endcase
      return pattern[pos];
   endfunction

endpackage

// ===== rtl/sqsw_sweep_calc.sv =====
`timescale 1ns / 1ps

module sqsw_sweep_adder (
   input  logic [sqsw_pkg::FREQ_W-1:0]  shadow,
   input  logic [sqsw_pkg::SHIFT_W-1:0] shift,
   input  logic                         negate,
   output sqsw_pkg::sweep_result_type   result
);
   import sqsw_pkg::*;

   logic [FREQ_W-1:0] delta;
   logic [FREQ_W:0]   next_freq;

   // shifted shadow added or subtracted, carry out marks overflow past 2047
   assign delta     = shadow >> shift;
   assign next_freq = negate ? ({1'b0, shadow} - {1'b0, delta})
                             : ({1'b0, shadow} + {1'b0, delta});

   assign result.freq     = next_freq[FREQ_W-1:0];
   assign result.overflow = next_freq[FREQ_W];

endmodule

// ===== rtl/square_wave_channel_sweep_unit.sv =====
`timescale 1ns / 1ps
// channel | direction | ports
// --------+-----------+----------------------------------------------------------
// req     | in        | req_valid/req_ready, operation, reg_index, write_data,
//         |           | volume, dac_enabled
// rsp     | out       | rsp_valid/rsp_ready, sample, read_data, channel_on
// csr     | in        | csr_write_enable/csr_write_data (power_on), no wait
//
// one item per cycle sustained while rsp_ready allows; request register then result register
// each item updates the channel state in the cycle it moves into the result register
// reset is synchronous: both stages empty, state cleared, power_on set
// a stalled result holds the request register, which keeps taking one item until it fills

module square_wave_channel_sweep_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic                              csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic [sqsw_pkg::REG_IDX_W-1:0]    req_reg_index,
   input  logic [sqsw_pkg::BYTE_W-1:0]       req_write_data,
   input  logic [sqsw_pkg::VOL_W-1:0]        req_volume,
   input  logic                              req_dac_enabled,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [sqsw_pkg::VOL_W-1:0] rsp_sample,
   output logic [sqsw_pkg::BYTE_W-1:0]       rsp_read_data,
   output logic                              rsp_channel_on
);
   import sqsw_pkg::*;
   `include "square_wave_channel_sweep_unit_defines.svh"

   // request register
   logic                  in_valid_ff, in_valid_in;
   op_type                in_op_ff;
   logic [REG_IDX_W-1:0]  in_idx_ff;
   logic [BYTE_W-1:0]     in_wdata_ff;
   logic [VOL_W-1:0]      in_vol_ff;
   logic                  in_dac_ff;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic [VOL_W-1:0]      out_sample_ff, out_sample_in;
   logic [BYTE_W-1:0]     out_rdata_ff, out_rdata_in;
   logic                  out_on_ff;

   // channel state
   logic                  power_on_ff;
   logic [TIMER_W-1:0]    period_timer_ff, period_timer_in;
   logic [WAVE_W-1:0]     wave_pos_ff, wave_pos_in;
   logic [DUTY_W-1:0]     duty_ff, duty_in;
   logic [FREQ_W-1:0]     tone_ff, tone_in;
   logic [FREQ_W-1:0]     shadow_ff, shadow_in;
   logic [SWP_PER_W-1:0]  swp_period_ff, swp_period_in;
   logic [SWP_CNT_W-1:0]  swp_count_ff, swp_count_in;
   logic                  swp_negate_ff, swp_negate_in;
   logic [SHIFT_W-1:0]    swp_shift_ff, swp_shift_in;
   logic                  swp_active_ff, swp_active_in;
   logic                  negate_used_ff, negate_used_in;
   logic                  enabled_ff, enabled_in;
   logic                  length_en_ff, length_en_in;

   logic                  advance;
   logic                  req_take;
   logic [FREQ_W-1:0]     tone_hi;
   logic [FREQ_W-1:0]     calc_first_shadow;
   logic [SWP_CNT_W-1:0]  swp_reload;
   sweep_result_type      calc_first, calc_second;

   // handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // frequency after a high-byte write, also the trigger's shadow
   assign tone_hi           = {in_wdata_ff[2:0], tone_ff[7:0]};
   assign calc_first_shadow = (in_op_ff == OP_WRITE) ? tone_hi : shadow_ff;
   assign swp_reload        = (swp_period_ff == '0) ? SWEEP_IDLE_RELOAD
                                                    : {1'b0, swp_period_ff};

   // first calculation serves sweep ticks and triggers
   sqsw_sweep_adder u_calc_first (
      .shadow (calc_first_shadow),
      .shift  (swp_shift_ff),
      .negate (swp_negate_ff),
      .result (calc_first)
   );

   // second calculation checks the freshly written frequency on a sweep tick
   sqsw_sweep_adder u_calc_second (
      .shadow (calc_first.freq),
      .shift  (swp_shift_ff),
      .negate (swp_negate_ff),
      .result (calc_second)
   );

   // state update and result for the item in the request register
   always_comb begin
      period_timer_in = period_timer_ff;
      wave_pos_in     = wave_pos_ff;
      duty_in         = duty_ff;
      tone_in         = tone_ff;
      shadow_in       = shadow_ff;
      swp_period_in   = swp_period_ff;
      swp_count_in    = swp_count_ff;
      swp_negate_in   = swp_negate_ff;
      swp_shift_in    = swp_shift_ff;
      swp_active_in   = swp_active_ff;
      negate_used_in  = negate_used_ff;
      enabled_in      = enabled_ff;
      length_en_in    = length_en_ff;
      out_rdata_in    = '0;

      case (in_op_ff)
         OP_TIMER: begin
            if (period_timer_ff <= TIMER_W'(1)) begin
               period_timer_in = reload_value(tone_ff);
               wave_pos_in     = wave_pos_ff + WAVE_W'(1);
            end else begin
               period_timer_in = period_timer_ff - TIMER_W'(1);
            end
         end
         OP_SWEEP: begin
            if (swp_count_ff <= SWP_CNT_W'(1)) begin
               swp_count_in = swp_reload;
               if (swp_active_ff && swp_period_ff != '0) begin
                  if (swp_negate_ff) begin
                     negate_used_in = 1'b1;
                  end
                  if (calc_first.overflow) begin
                     enabled_in = 1'b0;
                  end else if (swp_shift_ff != '0) begin
                     tone_in   = calc_first.freq;
                     shadow_in = calc_first.freq;
                     if (calc_second.overflow) begin
                        enabled_in = 1'b0;
                     end
                  end
               end
            end else begin
               swp_count_in = swp_count_ff - SWP_CNT_W'(1);
            end
         end
         OP_WRITE: begin
            case (in_idx_ff)
               REG_SWEEP: begin
                  swp_period_in = in_wdata_ff[6:4];
                  swp_negate_in = in_wdata_ff[3];
                  swp_shift_in  = in_wdata_ff[2:0];
                  // clearing negate after a negate calculation kills the channel
                  if (negate_used_ff && !in_wdata_ff[3]) begin
                     enabled_in     = 1'b0;
                     negate_used_in = 1'b0;
                  end
               end
               REG_DUTY: begin
                  if (power_on_ff) begin
                     duty_in = in_wdata_ff[7:6];
                  end
               end
               REG_FREQ_LO: begin
                  tone_in = {tone_ff[10:8], in_wdata_ff};
               end
               REG_FREQ_HI: begin
                  length_en_in = in_wdata_ff[6];
                  tone_in      = tone_hi;
                  // trigger
                  if (in_wdata_ff[7]) begin
                     if (in_dac_ff) begin
                        enabled_in = 1'b1;
                     end
                     period_timer_in = reload_value(tone_hi);
                     wave_pos_in     = '0;
                     negate_used_in  = 1'b0;
                     shadow_in       = tone_hi;
                     swp_count_in    = swp_reload;
                     swp_active_in   = (swp_period_ff != '0) || (swp_shift_ff != '0);
                     if (swp_shift_ff != '0) begin
                        if (swp_negate_ff) begin
                           negate_used_in = 1'b1;
                        end
                        if (calc_first.overflow) begin
                           enabled_in = 1'b0;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         OP_READ: begin
            case (in_idx_ff)
               REG_SWEEP:    out_rdata_in = RD_SWEEP_FILL
                                          | {1'b0, swp_period_ff, swp_negate_ff, swp_shift_ff};
               REG_DUTY:     out_rdata_in = {duty_ff, 6'b0} | RD_DUTY_FILL;
               REG_ENVELOPE: out_rdata_in = '0;
               REG_FREQ_LO:  out_rdata_in = RD_ALL_ONES;
               REG_FREQ_HI:  out_rdata_in = {1'b0, length_en_ff, 6'b0} | RD_HI_FILL;
               default:      out_rdata_in = RD_ALL_ONES;
            endcase
         end
         default: begin
         end
      endcase

      // sample from the updated state
      if (!enabled_in) begin
         out_sample_in = '0;
      end else if (duty_bit(duty_in, wave_pos_in)) begin
         out_sample_in = in_vol_ff - VOL_W'(8);
      end else begin
         out_sample_in = {1'b1, {(VOL_W-1){1'b0}}};
      end
   end

   // handshake and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         power_on_ff  <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            power_on_ff <= csr_write_data;
         end
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff    <= op_type'(req_operation);
         in_idx_ff   <= req_reg_index;
         in_wdata_ff <= req_write_data;
         in_vol_ff   <= req_volume;
         in_dac_ff   <= req_dac_enabled;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_sample_ff <= out_sample_in;
         out_rdata_ff  <= out_rdata_in;
         out_on_ff     <= enabled_in;
      end
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_timer_ff <= '0;
         wave_pos_ff     <= '0;
         duty_ff         <= '0;
         tone_ff         <= '0;
         shadow_ff       <= '0;
         swp_period_ff   <= '0;
         swp_count_ff    <= '0;
         swp_negate_ff   <= 1'b0;
         swp_shift_ff    <= '0;
         swp_active_ff   <= 1'b0;
         negate_used_ff  <= 1'b0;
         enabled_ff      <= 1'b0;
         length_en_ff    <= 1'b0;
      end else if (advance) begin
         period_timer_ff <= period_timer_in;
         wave_pos_ff     <= wave_pos_in;
         duty_ff         <= duty_in;
         tone_ff         <= tone_in;
         shadow_ff       <= shadow_in;
         swp_period_ff   <= swp_period_in;
         swp_count_ff    <= swp_count_in;
         swp_negate_ff   <= swp_negate_in;
         swp_shift_ff    <= swp_shift_in;
         swp_active_ff   <= swp_active_in;
         negate_used_ff  <= negate_used_in;
         enabled_ff      <= enabled_in;
         length_en_ff    <= length_en_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_sample     = $signed(out_sample_ff);
   assign rsp_read_data  = out_rdata_ff;
   assign rsp_channel_on = out_on_ff;

   // checks
   `SQSW_ASSERT(a_silent_when_off, clock, reset, (rsp_valid && !rsp_channel_on) |-> (rsp_sample == '0), "sample not zero while channel off")
   `SQSW_ASSERT_NEXT(a_rdata_only_on_read, clock, reset, advance && in_op_ff != OP_READ, rsp_read_data == '0, "read data on a non-read item")
   `SQSW_ASSERT_NEXT(a_timer_count_down, clock, reset, advance && in_op_ff == OP_TIMER && period_timer_ff > TIMER_W'(1), period_timer_ff == $past(period_timer_ff) - TIMER_W'(1), "period timer did not count down")
   `SQSW_ASSERT(a_sweep_count_range, clock, reset, swp_count_ff <= SWEEP_IDLE_RELOAD, "sweep countdown out of range")
   `SQSW_ASSERT_NEXT(a_result_follows, clock, reset, advance, rsp_valid && rsp_channel_on == $past(enabled_in), "result register missed an item")

endmodule
